// ----- rtl/core/cswt_pkg.sv -----
// ----------------------------------------------------------------------------
// cswt_pkg
// Types, constants and character classification shared by the tokenizer.
// ----------------------------------------------------------------------------
package cswt_pkg;

  // token codes
  localparam logic [4:0] T_POW   = 5'd26;
  localparam logic [4:0] T_SCALE = 5'd27;
  localparam logic [4:0] T_END   = 5'd30;
  localparam logic [4:0] T_START = 5'd31;

  // most tokens one item can cause
  localparam int MAX_RES = 5;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int IDX_W   = $clog2(MAX_RES);

  // default depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // input item commands
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_EOW  = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] ch;
  } in_item_t;

  typedef struct packed {
    logic [4:0] token;
    logic       run_last;
    logic       word_end;
    logic       error;
  } out_item_t;

  // one input item worth of results, built by the front
  typedef struct packed {
    logic [MAX_RES-1:0][4:0] toks;
    logic [CNT_W-1:0]        cnt;
    logic                    err;
    logic                    word_end;
  } job_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    CC_DIGIT,
    CC_WORD,
    CC_SPECIAL,
    CC_PUNCT,
    CC_BAD
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [4:0]  code;
  } char_info_t;

  // index of a byte in the punctuation list, valid flag in the top bit
  function automatic logic [5:0] punct_lookup(input logic [7:0] c);
    logic [5:0] r;
    r = '0;
    case (c)
      8'h21: r = {1'b1, 5'd0};   // !
      8'h22: r = {1'b1, 5'd1};   // "
      8'h23: r = {1'b1, 5'd2};   // #
      8'h24: r = {1'b1, 5'd3};   // $
      8'h25: r = {1'b1, 5'd4};   // %
      8'h26: r = {1'b1, 5'd5};   // &
      8'h27: r = {1'b1, 5'd6};   // '
      8'h28: r = {1'b1, 5'd7};   // (
      8'h29: r = {1'b1, 5'd8};   // )
      8'h2a: r = {1'b1, 5'd9};   // *
      8'h2b: r = {1'b1, 5'd10};  // +
      8'h2c: r = {1'b1, 5'd11};  // ,
      8'h2f: r = {1'b1, 5'd12};  // /
      8'h3a: r = {1'b1, 5'd13};  // :
      8'h3b: r = {1'b1, 5'd14};  // ;
      8'h3c: r = {1'b1, 5'd15};  // <
      8'h3d: r = {1'b1, 5'd16};  // =
      8'h3e: r = {1'b1, 5'd17};  // >
      8'h3f: r = {1'b1, 5'd18};  // ?
      8'h5b: r = {1'b1, 5'd19};  // [
      8'h5c: r = {1'b1, 5'd20};  // backslash
      8'h5d: r = {1'b1, 5'd21};  // ]
      8'h5e: r = {1'b1, 5'd22};  // ^
      8'h5f: r = {1'b1, 5'd23};  // _
      8'h60: r = {1'b1, 5'd24};  // backtick
      8'h7b: r = {1'b1, 5'd25};  // {
      8'h7c: r = {1'b1, 5'd26};  // |
      8'h7d: r = {1'b1, 5'd27};  // }
      default: r = '0;
    endcase
    return r;
  endfunction

  // class and in-context code of one byte
  function automatic char_info_t classify(input logic [7:0] c);
    char_info_t ci;
    logic [5:0] p;
    logic [7:0] diff;
    p       = punct_lookup(c);
    ci.cls  = CC_BAD;
    ci.code = '0;
    if (c inside {[8'h30:8'h39]}) begin
      diff    = c - 8'h30;
      ci.cls  = CC_DIGIT;
      ci.code = diff[4:0];
    end else if (c inside {[8'h41:8'h5a]}) begin
      diff    = c - 8'h41;
      ci.cls  = CC_WORD;
      ci.code = diff[4:0];
    end else if (c == 8'h20) begin
      ci.cls  = CC_WORD;
      ci.code = T_POW;
    end else if (c == 8'h2e) begin
      ci.cls  = CC_WORD;
      ci.code = T_SCALE;
    end else if (c inside {[8'h61:8'h7a]}) begin
      diff    = c - 8'h61;
      ci.cls  = CC_SPECIAL;
      ci.code = diff[4:0];
    end else if (c == 8'h40) begin
      ci.cls  = CC_SPECIAL;
      ci.code = T_POW;
    end else if (c == 8'h2d) begin
      ci.cls  = CC_SPECIAL;
      ci.code = T_SCALE;
    end else if (p[5]) begin
      ci.cls  = CC_PUNCT;
      ci.code = p[4:0];
    end
    return ci;
  endfunction

endpackage

// ----- rtl/core/cswt_front.sv -----
// ----------------------------------------------------------------------------
// cswt_front
// Accepts input items, tracks the coder context and builds each item's run.
// ----------------------------------------------------------------------------
module cswt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  cswt_pkg::in_item_t  in_data,
  input  cswt_pkg::q_status_t q_status,
  output logic                enq,
  output cswt_pkg::job_t      enq_job
);
  import cswt_pkg::*;

  logic [1:0] depth_r, depth_nxt;
  logic       word_open_r, word_open_nxt;
  logic       discarding_r, discarding_nxt;

  logic             accept;
  char_info_t       ci;
  logic [4:0]       t [MAX_RES];
  logic [CNT_W-1:0] n;
  logic             err;
  logic             we;

  assign full   = q_status.full;
  assign accept = push && !q_status.full;
  assign ci     = classify(in_data.ch);

  // build the token run and the next context
  always_comb begin
    for (int i = 0; i < MAX_RES; i++) t[i] = '0;
    n              = '0;
    err            = 1'b0;
    we             = 1'b0;
    depth_nxt      = depth_r;
    word_open_nxt  = word_open_r;
    discarding_nxt = discarding_r;

    if (in_data.cmd == CMD_EOW) begin
      if (discarding_r) begin
        depth_nxt      = '0;
        word_open_nxt  = 1'b0;
        discarding_nxt = 1'b0;
      end else begin
        if (!word_open_r) begin
          t[n] = T_START; n = n + 1'b1;
          depth_nxt = '0;
        end
        for (int k = 0; k < 3; k++) begin
          if (2'(k) < depth_nxt) begin
            t[n] = T_END; n = n + 1'b1;
          end
        end
        t[n] = T_END; n = n + 1'b1;
        we            = 1'b1;
        word_open_nxt = 1'b0;
        depth_nxt     = '0;
      end
    end else if (!discarding_r) begin
      // open the word unless the byte is uncodeable
      if (ci.cls != CC_BAD && !word_open_r) begin
        t[n] = T_START; n = n + 1'b1;
        word_open_nxt = 1'b1;
        depth_nxt     = '0;
      end
      case (ci.cls)
        CC_DIGIT: begin
          for (int k = 0; k < 3; k++) begin
            if (2'(k) < depth_nxt) begin
              t[n] = T_END; n = n + 1'b1;
            end
          end
          depth_nxt = '0;
          t[n] = T_END;   n = n + 1'b1;
          t[n] = ci.code; n = n + 1'b1;
          t[n] = T_START; n = n + 1'b1;
        end
        CC_WORD: begin
          for (int k = 0; k < 3; k++) begin
            if (2'(k) < depth_nxt) begin
              t[n] = T_END; n = n + 1'b1;
            end
          end
          depth_nxt = '0;
          t[n] = ci.code; n = n + 1'b1;
        end
        CC_SPECIAL: begin
          if (depth_nxt > 2'd1) begin
            t[n] = T_END; n = n + 1'b1;
            depth_nxt = 2'd1;
          end else if (depth_nxt < 2'd1) begin
            t[n] = T_START; n = n + 1'b1;
            depth_nxt = 2'd1;
          end
          t[n] = ci.code; n = n + 1'b1;
        end
        CC_PUNCT: begin
          if (depth_nxt < 2'd2) begin
            if (depth_nxt < 2'd1) begin
              t[n] = T_START; n = n + 1'b1;
            end
            t[n] = T_START; n = n + 1'b1;
            depth_nxt = 2'd2;
          end
          t[n] = ci.code; n = n + 1'b1;
        end
        default: begin
          // uncodeable byte: single error result, drop rest of word
          t[n] = '0; n = n + 1'b1;
          err            = 1'b1;
          we             = 1'b1;
          discarding_nxt = 1'b1;
        end
      endcase
    end
  end

  // job for the queue
  always_comb begin
    for (int i = 0; i < MAX_RES; i++) enq_job.toks[i] = t[i];
    enq_job.cnt      = n;
    enq_job.err      = err;
    enq_job.word_end = we;
  end

  assign enq = accept && (n != '0);

  // context state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r      <= '0;
      word_open_r  <= 1'b0;
      discarding_r <= 1'b0;
    end else if (accept) begin
      depth_r      <= depth_nxt;
      word_open_r  <= word_open_nxt;
      discarding_r <= discarding_nxt;
    end
  end

endmodule

// ----- rtl/core/cswt_queue.sv -----
// ----------------------------------------------------------------------------
// cswt_queue
// Short job queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module cswt_queue #(
  parameter int Depth = cswt_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  cswt_pkg::job_t      wr_data,
  input  logic                rd_en,
  output cswt_pkg::job_t      rd_data,
  output cswt_pkg::q_status_t status
);
  import cswt_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign status.full  = (count_r == FullCnt);
  assign status.empty = (count_r == '0);
  assign rd_data      = mem[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    if (rd_en) rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    if (wr_en && !rd_en) count_nxt = count_r + 1'b1;
    else if (rd_en && !wr_en) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr_r] <= wr_data;
  end

endmodule

// ----- rtl/core/cswt_back.sv -----
// ----------------------------------------------------------------------------
// cswt_back
// Steps the run into the output register, one token per cycle unless stalled.
// ----------------------------------------------------------------------------
module cswt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  cswt_pkg::job_t      head,
  input  cswt_pkg::q_status_t q_status,
  output logic                deq,
  output logic                empty,
  input  logic                pop,
  output cswt_pkg::out_item_t out_data
);
  import cswt_pkg::*;

  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             load;
  logic             last;
  logic [CNT_W-1:0] idx_inc;

  assign empty    = !out_valid_r;
  assign out_data = out_data_r;

  // next token of the head run into the output slot
  always_comb begin
    load    = !q_status.empty && (!out_valid_r || pop);
    idx_inc = CNT_W'(idx_r) + 1'b1;
    last    = (idx_inc == head.cnt);
    deq     = load && last;

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    idx_nxt       = idx_r;
    if (pop && out_valid_r) out_valid_nxt = 1'b0;
    if (load) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.token    = head.toks[idx_r];
      out_data_nxt.run_last = last;
      out_data_nxt.word_end = last && head.word_end;
      out_data_nxt.error    = head.err;
      idx_nxt               = last ? '0 : idx_inc[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- rtl/core/context_switching_word_tokenizer_unit.sv -----
// ----------------------------------------------------------------------------
// context_switching_word_tokenizer_unit
// Character-per-item word coder emitting 5-bit context-switching tokens.
// ----------------------------------------------------------------------------
// Push one character, or an end-of-word marker, per transaction; the block
// pops out the 5-bit tokens of the context-switching word coder, one per
// transaction, with run_last on the last token of each item and word_end on the
// final token or error of a word. The front takes one item per cycle whenever
// the job queue (QueueDepth entries) has room and builds the whole token run
// of that item in the same cycle. The back delivers one token per cycle while
// the output register is free or popped, so an item takes one output slot per
// token: none for bytes dropped after an error, one for most characters, up to
// five for a digit that closes two nested contexts. Sustained throughput is set
// by the output channel at one token per cycle; the first token of an item
// passes through the job queue and then the output register to the ports.
// ----------------------------------------------------------------------------
module context_switching_word_tokenizer_unit #(
  parameter int QueueDepth = cswt_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  cswt_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output cswt_pkg::out_item_t out_data
);
  import cswt_pkg::*;

  logic      enq;
  logic      deq;
  job_t      enq_job;
  job_t      head;
  q_status_t q_status;

  // classify and build token runs
  cswt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .q_status (q_status),
    .enq      (enq),
    .enq_job  (enq_job)
  );

  // decoupling queue
  cswt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (enq),
    .wr_data (enq_job),
    .rd_en   (deq),
    .rd_data (head),
    .status  (q_status)
  );

  // token sequencer and output register
  cswt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_status (q_status),
    .deq      (deq),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule
